@@ rtl/tun_pkg.sv @@
// Package for triangle_unit_normal: payload structs and fixed widths.
// No dependencies.
package tun_pkg;

  localparam int CoordBits = 16;
  localparam int FracBits = 14;
  localparam int OutBits = 16;
  localparam int PreBits = 30;

  typedef struct packed {
    logic signed [CoordBits-1:0] v1_x;
    logic signed [CoordBits-1:0] v1_y;
    logic signed [CoordBits-1:0] v1_z;
    logic signed [CoordBits-1:0] v2_x;
    logic signed [CoordBits-1:0] v2_y;
    logic signed [CoordBits-1:0] v2_z;
    logic signed [CoordBits-1:0] v3_x;
    logic signed [CoordBits-1:0] v3_y;
    logic signed [CoordBits-1:0] v3_z;
  } tri_in_t;

  typedef struct packed {
    logic signed [OutBits-1:0] norm_x;
    logic signed [OutBits-1:0] norm_y;
    logic signed [OutBits-1:0] norm_z;
    logic                      degenerate;
  } tri_out_t;

endpackage

@@ rtl/tun_cross.sv @@
// Edge vectors and cross product stages, then sign/magnitude and prescale to 30 bits.
// Depends on tun_pkg.
module tun_cross (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  in_valid,
  input  tun_pkg::tri_in_t      in_data,
  output logic                  out_valid,
  output logic [29:0]           mag [3],
  output logic [2:0]            neg,
  output logic                  degen
);
  localparam int DW = tun_pkg::CoordBits + 1;
  localparam int NW = 2 * DW + 1;

  logic                 v1, v2, v3;
  logic signed [DW-1:0] p [3];
  logic signed [DW-1:0] q [3];
  logic signed [2*DW-1:0] pr [6];
  logic [NW-1:0]        am [3];
  logic [2:0]           ng;
  logic [NW-1:0]        nn [3];
  logic [NW-1:0]        orv;
  logic [5:0]           sh;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0; v2 <= 1'b0; v3 <= 1'b0;
    end else begin
      v1 <= in_valid; v2 <= v1; v3 <= v2;
    end
    q[0] <= DW'(in_data.v2_x) - DW'(in_data.v1_x);
    q[1] <= DW'(in_data.v2_y) - DW'(in_data.v1_y);
    q[2] <= DW'(in_data.v2_z) - DW'(in_data.v1_z);
    p[0] <= DW'(in_data.v3_x) - DW'(in_data.v1_x);
    p[1] <= DW'(in_data.v3_y) - DW'(in_data.v1_y);
    p[2] <= DW'(in_data.v3_z) - DW'(in_data.v1_z);
    pr[0] <= p[1] * q[2]; pr[1] <= p[2] * q[1];
    pr[2] <= p[2] * q[0]; pr[3] <= p[0] * q[2];
    pr[4] <= p[0] * q[1]; pr[5] <= p[1] * q[0];
    for (int i = 0; i < 3; i++) begin
      ng[i] <= nn[i][NW-1];
      am[i] <= nn[i][NW-1] ? -nn[i] : nn[i];
    end
  end

  always_comb begin
    for (int i = 0; i < 3; i++)
      nn[i] = NW'(pr[2*i]) - NW'(pr[2*i+1]);
  end

  // Prescale: shift by bit length minus 30 when longer.
  always_comb begin
    orv = am[0] | am[1] | am[2];
    sh = '0;
    for (int b = 0; b < NW; b++)
      if (orv[b] && b >= tun_pkg::PreBits) sh = 6'(b - tun_pkg::PreBits + 1);
  end

  always_ff @(posedge clk) begin
    if (rst) out_valid <= 1'b0;
    else out_valid <= v3;
    for (int i = 0; i < 3; i++) mag[i] <= 30'(am[i] >> sh);
    neg   <= ng;
    degen <= (orv == '0);
  end
endmodule

@@ rtl/tun_root.sv @@
// Bit-serial pipelined search r = round(m*2^F/sqrt(s)), one result bit a stage.
// Depends on tun_pkg.
module tun_root (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  input  logic [29:0] mag [3],
  input  logic [2:0]  neg,
  input  logic        degen,
  output logic        out_valid,
  output tun_pkg::tri_out_t out_data
);
  localparam int F = tun_pkg::FracBits;
  localparam int NS = F + 2;

  logic [61:0] sq [3];
  logic [2:0]  ng0;
  logic        dg0, vl0;
  logic [62:0] s;

  logic        vl [NS];
  logic [62:0] ss [NS];
  logic [95:0] rh [NS][3];
  // Running products for the accepted r: (2r-1)^2*s and (2r-1)*s (two's complement).
  logic [95:0] ea [NS][3];
  logic [95:0] ga [NS][3];
  logic [F:0]  r  [NS][3];
  logic [2:0]  ngs [NS];
  logic        dgs [NS];

  always_ff @(posedge clk) begin
    if (rst) vl0 <= 1'b0;
    else vl0 <= in_valid;
    for (int i = 0; i < 3; i++) begin
      sq[i] <= mag[i] * mag[i];
    end
    ng0 <= neg;
    dg0 <= degen;
  end
  assign s = 63'(sq[0]) + 63'(sq[1]) + 63'(sq[2]);

  always_ff @(posedge clk) begin
    if (rst) vl[0] <= 1'b0;
    else vl[0] <= vl0;
    ss[0] <= s;
    for (int i = 0; i < 3; i++) begin
      rh[0][i] <= 96'(sq[i]) << (2 * F + 2);
      ea[0][i] <= 96'(s);
      ga[0][i] <= -96'(s);
      r[0][i] <= '0;
    end
    ngs[0] <= ng0;
    dgs[0] <= dg0;
  end

  // Setting bit B adds 2^(B+1) to 2r-1, so the products advance by shifts and adds.
  for (genvar k = 1; k < NS; k++) begin : g_bit
    localparam int B = F + 1 - k;
    logic [F:0]  t [3];
    logic [95:0] ec [3];
    logic        hit [3];
    always_comb begin
      for (int i = 0; i < 3; i++) begin
        t[i] = r[k-1][i] | ((F+1)'(1) << B);
        ec[i] = ea[k-1][i] + (ga[k-1][i] << (B + 2))
                + (96'(ss[k-1]) << (2 * B + 2));
        hit[i] = (t[i] <= (F+1)'(1) << F) && (ec[i] <= rh[k-1][i]);
      end
    end
    always_ff @(posedge clk) begin
      if (rst) vl[k] <= 1'b0;
      else vl[k] <= vl[k-1];
      ss[k] <= ss[k-1];
      ngs[k] <= ngs[k-1];
      dgs[k] <= dgs[k-1];
      for (int i = 0; i < 3; i++) begin
        rh[k][i] <= rh[k-1][i];
        if (hit[i]) begin
          r[k][i] <= t[i];
          ea[k][i] <= ec[i];
          ga[k][i] <= ga[k-1][i] + (96'(ss[k-1]) << (B + 1));
        end else begin
          r[k][i] <= r[k-1][i];
          ea[k][i] <= ea[k-1][i];
          ga[k][i] <= ga[k-1][i];
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) out_valid <= 1'b0;
    else out_valid <= vl[NS-1];
    out_data.degenerate <= dgs[NS-1];
    out_data.norm_x <= dgs[NS-1] ? '0 :
      (ngs[NS-1][0] ? -16'(r[NS-1][0]) : 16'(r[NS-1][0]));
    out_data.norm_y <= dgs[NS-1] ? '0 :
      (ngs[NS-1][1] ? -16'(r[NS-1][1]) : 16'(r[NS-1][1]));
    out_data.norm_z <= dgs[NS-1] ? '0 :
      (ngs[NS-1][2] ? -16'(r[NS-1][2]) : 16'(r[NS-1][2]));
  end
endmodule

@@ rtl/triangle_unit_normal.sv @@
// Top level of the triangle unit normal pipeline.
// Depends on tun_pkg, tun_cross, tun_root.
//
//  channel | handshake     | payload
//  input   | start / busy  | tri_in  (tun_pkg::tri_in_t)
//  result  | done strobe   | tri_out (tun_pkg::tri_out_t)
//
// One triangle may transfer every cycle; busy stays low.
// Latency is set by the one-bit-per-stage normalize search.
// Reset clears the valid bits of every stage; payload holds no reset.
// The receiver cannot stall, so each result shows for exactly one cycle.
module triangle_unit_normal (
  input  logic              clk,
  input  logic              rst,
  input  logic              start,
  output logic              busy,
  input  tun_pkg::tri_in_t  tri_in,
  output logic              done,
  output tun_pkg::tri_out_t tri_out
);
  logic        cv;
  logic [29:0] mag [3];
  logic [2:0]  neg;
  logic        degen;

  // Accept always: the pipeline never holds.
  assign busy = 1'b0;

  tun_cross u_cross (
    .clk(clk), .rst(rst), .in_valid(start), .in_data(tri_in),
    .out_valid(cv), .mag(mag), .neg(neg), .degen(degen)
  );

  tun_root u_root (
    .clk(clk), .rst(rst), .in_valid(cv), .mag(mag), .neg(neg), .degen(degen),
    .out_valid(done), .out_data(tri_out)
  );

`ifndef ASSERT_OFF
  a_degen_zero: assert property (@(posedge clk) disable iff (rst)
    done && tri_out.degenerate |-> tri_out.norm_x == 0 && tri_out.norm_y == 0
      && tri_out.norm_z == 0) else $error("degenerate with nonzero normal");
  a_range: assert property (@(posedge clk) disable iff (rst)
    done |-> tri_out.norm_x <= 16384 && tri_out.norm_x >= -16384)
    else $error("norm_x out of range");
  a_latency: assert property (@(posedge clk) disable iff (rst)
    cv |-> ##18 done) else $error("pipeline lost an item");
`endif
endmodule

@@ tb/sv/triangle_unit_normal_check.sv @@
// Checker for triangle_unit_normal: predicts each unit normal and compares results.
// Depends on tun_pkg.
module triangle_unit_normal_check (
  input  logic              clk,
  input  logic              rst,
  input  logic              start,
  input  logic              busy,
  input  tun_pkg::tri_in_t  tri_in,
  input  logic              done,
  input  tun_pkg::tri_out_t tri_out,
  output int                fail_count,
  output int                pending,
  output int                normals_seen,
  output int                flat_seen
);
  timeunit 1ns;
  timeprecision 1ps;

  tun_pkg::tri_out_t normal_queue[$];

  task automatic report_mismatch(input string what, input logic [15:0] got,
                                 input logic [15:0] want);
    $display("mismatch %s: got %h want %h at %0t", what, got, want, $realtime);
    fail_count++;
  endtask

  function automatic logic [15:0] unit_component(logic [63:0] m, logic [63:0] s);
    logic [127:0] rhs;
    logic [127:0] lhs;
    logic [63:0] r;
    logic [63:0] t;
    logic [63:0] d;
    rhs = {64'd0, m * m} << (2 * tun_pkg::FracBits + 2);
    r = 0;
    for (int b = tun_pkg::FracBits; b >= 0; b--) begin
      t = r | (64'd1 << b);
      d = 2 * t - 1;
      lhs = {64'd0, d * d} * {64'd0, s};
      if (t <= (64'd1 << tun_pkg::FracBits) && lhs <= rhs) r = t;
    end
    return r[15:0];
  endfunction

  function automatic tun_pkg::tri_out_t predict_normal(tun_pkg::tri_in_t v);
    logic signed [17:0] px, py, pz, qx, qy, qz;
    logic signed [39:0] n [3];
    logic [39:0] mag [3];
    logic neg [3];
    int maxlen, sh;
    logic [63:0] s;
    logic [15:0] r [3];
    tun_pkg::tri_out_t o;
    qx = v.v2_x - v.v1_x; qy = v.v2_y - v.v1_y; qz = v.v2_z - v.v1_z;
    px = v.v3_x - v.v1_x; py = v.v3_y - v.v1_y; pz = v.v3_z - v.v1_z;
    n[0] = py * qz - pz * qy;
    n[1] = pz * qx - px * qz;
    n[2] = px * qy - py * qx;
    maxlen = 0;
    for (int i = 0; i < 3; i++) begin
      neg[i] = n[i] < 0;
      mag[i] = neg[i] ? -n[i] : n[i];
      for (int b = 0; b < 40; b++) if (mag[i][b] && b + 1 > maxlen) maxlen = b + 1;
    end
    o = '0;
    if (maxlen == 0) begin
      o.degenerate = 1'b1;
      return o;
    end
    sh = (maxlen > tun_pkg::PreBits) ? maxlen - tun_pkg::PreBits : 0;
    s = 0;
    for (int i = 0; i < 3; i++) begin
      mag[i] = mag[i] >> sh;
      s += {24'd0, mag[i]} * {24'd0, mag[i]};
    end
    for (int i = 0; i < 3; i++) begin
      r[i] = unit_component({24'd0, mag[i]}, s);
      if (neg[i]) r[i] = -r[i];
    end
    o.norm_x = r[0]; o.norm_y = r[1]; o.norm_z = r[2];
    return o;
  endfunction

  // Sample at the edge; inputs change via NBA so values are pre-edge.
  always @(posedge clk) begin
    tun_pkg::tri_out_t want;
    if (rst) begin
      fail_count <= fail_count;
    end else begin
      if (start && !busy) begin
        normal_queue.push_back(predict_normal(tri_in));
        pending++;
      end
      if (done) begin
        normals_seen++;
        if (normal_queue.size() == 0) begin
          report_mismatch("unexpected result", tri_out[15:0], 16'd0);
        end else begin
          want = normal_queue.pop_front();
          pending--;
          if (want.degenerate) flat_seen++;
          if (tri_out.norm_x !== want.norm_x)
            report_mismatch("norm_x", tri_out.norm_x, want.norm_x);
          if (tri_out.norm_y !== want.norm_y)
            report_mismatch("norm_y", tri_out.norm_y, want.norm_y);
          if (tri_out.norm_z !== want.norm_z)
            report_mismatch("norm_z", tri_out.norm_z, want.norm_z);
          if (tri_out.degenerate !== want.degenerate)
            report_mismatch("degenerate", 16'(tri_out.degenerate),
                            16'(want.degenerate));
        end
      end
    end
  end

  initial begin
    fail_count = 0;
    pending = 0;
    normals_seen = 0;
    flat_seen = 0;
  end
endmodule

@@ tb/sv/triangle_unit_normal_test.sv @@
// Testbench top for triangle_unit_normal: drives triangles and gives the verdict.
// Depends on tun_pkg, triangle_unit_normal and triangle_unit_normal_check.
module triangle_unit_normal_test;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int Latency = 22;
  localparam int CycleLimit = 200000;

  logic clk;
  logic rst;
  logic start;
  logic busy;
  logic done;
  tun_pkg::tri_in_t tri_in;
  tun_pkg::tri_out_t tri_out;
  int fail_count, pending, normals_seen, flat_seen;
  int cycle_count;
  int idle_pct;

  triangle_unit_normal uut (
    .clk(clk), .rst(rst), .start(start), .busy(busy),
    .tri_in(tri_in), .done(done), .tri_out(tri_out)
  );

  triangle_unit_normal_check checker_inst (
    .clk(clk), .rst(rst), .start(start), .busy(busy), .tri_in(tri_in),
    .done(done), .tri_out(tri_out), .fail_count(fail_count), .pending(pending),
    .normals_seen(normals_seen), .flat_seen(flat_seen)
  );

  initial begin
    clk = 0;
    forever #5 clk = ~clk;
  end

  // Watchdog: end the run if the pipeline hangs.
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CycleLimit) begin
      $display("TB_ERROR");
      $finish;
    end
  end

  // Pick a coordinate: extremes often, otherwise full range or a small spread.
  function automatic logic [15:0] rand_coord();
    case ($urandom_range(0, 5))
      0: return 16'h8000;
      1: return 16'h7fff;
      2: return 16'($urandom_range(0, 64) - 32);
      default: return 16'($urandom);
    endcase
  endfunction

  function automatic tun_pkg::tri_in_t rand_triangle();
    tun_pkg::tri_in_t t;
    t.v1_x = rand_coord(); t.v1_y = rand_coord(); t.v1_z = rand_coord();
    case ($urandom_range(0, 9))
      // Degenerate: repeat a vertex or make the triangle collinear.
      0: begin
        t.v2_x = t.v1_x; t.v2_y = t.v1_y; t.v2_z = t.v1_z;
        t.v3_x = rand_coord(); t.v3_y = rand_coord(); t.v3_z = rand_coord();
      end
      1: begin
        t.v2_x = 16'(t.v1_x + 1); t.v2_y = 16'(t.v1_y + 2); t.v2_z = 16'(t.v1_z + 3);
        t.v3_x = 16'(t.v1_x + 2); t.v3_y = 16'(t.v1_y + 4); t.v3_z = 16'(t.v1_z + 6);
      end
      // Small triangles near the first vertex keep the normal well resolved.
      2, 3: begin
        t.v2_x = 16'(t.v1_x + $urandom_range(0, 8) - 4);
        t.v2_y = 16'(t.v1_y + $urandom_range(0, 8) - 4);
        t.v2_z = 16'(t.v1_z + $urandom_range(0, 8) - 4);
        t.v3_x = 16'(t.v1_x + $urandom_range(0, 8) - 4);
        t.v3_y = 16'(t.v1_y + $urandom_range(0, 8) - 4);
        t.v3_z = 16'(t.v1_z + $urandom_range(0, 8) - 4);
      end
      default: begin
        t.v2_x = rand_coord(); t.v2_y = rand_coord(); t.v2_z = rand_coord();
        t.v3_x = rand_coord(); t.v3_y = rand_coord(); t.v3_z = rand_coord();
      end
    endcase
    return t;
  endfunction

  // Hold start and the payload until the transfer, then drop or advance.
  task automatic send_triangle(input tun_pkg::tri_in_t t);
    while ($urandom_range(0, 99) < idle_pct) begin
      start <= 1'b0;
      @(posedge clk);
    end
    start <= 1'b1;
    tri_in <= t;
    @(posedge clk);
    while (busy) @(posedge clk);
  endtask

  task automatic send_axis(input logic [15:0] a, input logic [15:0] b,
                           input logic [15:0] c);
    tun_pkg::tri_in_t t;
    t = '0;
    t.v2_x = a; t.v3_y = b; t.v1_z = c;
    send_triangle(t);
  endtask

  initial begin
    tun_pkg::tri_in_t t;
    int wait_cycles;
    rst = 1'b1;
    start = 1'b0;
    tri_in = '0;
    cycle_count = 0;
    idle_pct = 0;
    repeat (3) @(posedge clk);
    rst <= 1'b0;

    // Directed: axis-aligned normals of both signs, extremes, zero area.
    send_axis(16'd1, 16'd1, 16'd0);
    send_axis(16'hffff, 16'd1, 16'd0);
    send_axis(16'h7fff, 16'h7fff, 16'd0);
    send_axis(16'h8000, 16'h7fff, 16'd0);
    send_axis(16'h8000, 16'h8000, 16'h7fff);
    send_axis(16'd3, 16'd4, 16'd5);
    t = '0;
    send_triangle(t);
    t = '1;
    send_triangle(t);
    t = {9{16'h8000}};
    send_triangle(t);
    t = '0; t.v1_x = 16'h8000; t.v1_y = 16'h8000; t.v1_z = 16'h8000;
    t.v2_x = 16'h7fff; t.v2_y = 16'h8000; t.v2_z = 16'h8000;
    t.v3_x = 16'h8000; t.v3_y = 16'h7fff; t.v3_z = 16'h7fff;
    send_triangle(t);
    t.v1_x = 16'h7fff; t.v1_y = 16'h7fff; t.v1_z = 16'h7fff;
    t.v2_x = 16'h8000; t.v2_y = 16'h7fff; t.v2_z = 16'h8000;
    t.v3_x = 16'h7fff; t.v3_y = 16'h8000; t.v3_z = 16'h8000;
    send_triangle(t);
    t = '0; t.v2_x = 16'd1; t.v2_y = 16'd1; t.v3_y = 16'd1; t.v3_z = 16'd1;
    send_triangle(t);
    t = '0; t.v2_x = 16'd2; t.v3_x = 16'd4;
    send_triangle(t);

    // Random phases: no idling, idle sender at 58 and 28 percent, then no idling again.
    for (int phase = 0; phase < 4; phase++) begin
      idle_pct = (phase == 1) ? 58 : (phase == 2) ? 28 : 0;
      for (int i = 0; i < 150; i++) send_triangle(rand_triangle());
    end
    start <= 1'b0;

    wait_cycles = 0;
    while (pending != 0 && wait_cycles < 10 * Latency) begin
      @(posedge clk);
      wait_cycles++;
    end
    repeat (Latency + 5) @(posedge clk);
    if (pending != 0) begin
      $display("%0d normals never arrived", pending);
    end
    $display("ran %0d triangles with %0d zero-area cases over %0d cycles",
             normals_seen, flat_seen, cycle_count);
    if (fail_count == 0 && pending == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end
endmodule
